>>> src/bsp_pkg.sv
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared constants and types for the per-pixel background subtraction block.
// ----------------------------------------------------------------------------
`default_nettype none

package bsp_pkg;

  // Frame size: one background/counter entry per pixel position
  localparam int unsigned PIXEL_COUNT = 262144;
  localparam int unsigned PIX_AW      = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

  // Field widths
  localparam int unsigned IDX_W   = 18;
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned ALPHA_W = 9;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_Q8         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SELECTIVE_UPDATE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STATIONARY_LIMIT = 2'd3;

  // Arithmetic constants
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 9'd256;
  localparam logic [CNT_W-1:0]   CNT_MAX     = 8'd255;
  localparam logic [CNT_W-1:0]   LIMIT_RESET = 8'd100;
  localparam logic [15:0]        ROUND_HALF  = 16'd128;

  // One entry of the per-pixel state memory
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [PIX_W-1:0] bkg;
  } bsp_word_t;

  localparam int unsigned WORD_W = $bits(bsp_word_t);

endpackage

`default_nettype wire

>>> src/background_subtraction_pixel.sv
// ----------------------------------------------------------------------------
// background_subtraction_pixel
// Pixels pass the stage A, B and C registers; C drives out_valid. One pixel
// per clock unless out_stall holds; each pixel does one read and, if in range,
// one write of the state RAM, with last-write forwarding for repeated indexes.
// Reset: rst_n (sync, active low) clears the valid flags and config registers;
// the state RAM is not cleared and holds undefined data until written.
// ----------------------------------------------------------------------------
`default_nettype none

module background_subtraction_pixel (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // configuration
  input  wire logic                             cfg_we,
  input  wire logic [bsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bsp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // pixel input
  input  wire logic                             in_valid,
  output      logic                             in_stall,
  input  wire logic [bsp_pkg::IDX_W-1:0]        in_pixel_index,
  input  wire logic [bsp_pkg::PIX_W-1:0]        in_luma,
  input  wire logic                             in_init_frame,
  // result output
  output      logic                             out_valid,
  input  wire logic                             out_stall,
  output      logic                             out_foreground,
  output      logic [bsp_pkg::PIX_W-1:0]        out_background_value
);

  import bsp_pkg::*;

  // configuration registers
  logic [PIX_W-1:0]   thr_r;
  logic [ALPHA_W-1:0] alpha_r;
  logic               sel_r;
  logic [CNT_W-1:0]   limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= '0;
      alpha_r <= '0;
      sel_r   <= 1'b0;
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIFF_THRESHOLD:   thr_r   <= cfg_wdata[PIX_W-1:0];
        CFG_ALPHA_Q8:         alpha_r <= (cfg_wdata > ALPHA_ONE) ? ALPHA_ONE : cfg_wdata;
        CFG_SELECTIVE_UPDATE: sel_r   <= cfg_wdata[0];
        CFG_STATIONARY_LIMIT: limit_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic a_valid_r, b_valid_r, c_valid_r;
  logic ready_a, ready_b, ready_c;
  logic in_xfer, adv_a, adv_b, out_xfer;

  assign ready_c  = !c_valid_r || !out_stall;
  assign ready_b  = !b_valid_r || ready_c;
  assign ready_a  = !a_valid_r || ready_b;
  assign in_stall = !ready_a;
  assign in_xfer  = in_valid && ready_a;
  assign adv_a    = a_valid_r && ready_b;
  assign adv_b    = b_valid_r && ready_c;
  assign out_xfer = c_valid_r && !out_stall;

  // stage A: input registers
  logic [IDX_W-1:0] a_idx_r;
  logic [PIX_W-1:0] a_luma_r;
  logic             a_init_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_xfer) begin
      a_valid_r <= 1'b1;
    end else if (adv_a) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_idx_r  <= in_pixel_index;
      a_luma_r <= in_luma;
      a_init_r <= in_init_frame;
    end
  end

  // last write to the state RAM, forwarded to the item in stage B
  logic             lw_valid_r;
  logic [IDX_W-1:0] lw_idx_r;
  logic [PIX_W-1:0] lw_bkg_r;
  logic [CNT_W-1:0] lw_cnt_r;

  // stage B: RAM data arrives, alpha*luma already formed
  logic [IDX_W-1:0] b_idx_r;
  logic [PIX_W-1:0] b_luma_r;
  logic             b_init_r;
  logic             b_oor_r;
  logic             b_fwd_r;
  logic [15:0]      b_p_r;

  logic             wr_now;
  logic [16:0]      a_prod;
  logic [15:0]      b_p_nxt;
  logic             b_fwd_nxt;
  logic             b_oor_nxt;

  assign a_prod    = alpha_r * a_luma_r;
  assign b_p_nxt   = a_prod[15:0] + ROUND_HALF;
  assign b_oor_nxt = (32'(a_idx_r) >= PIXEL_COUNT);
  assign wr_now    = adv_b && !b_oor_r;
  // when B writes at this edge it becomes the last write; otherwise lw stays
  assign b_fwd_nxt = wr_now ? (a_idx_r == b_idx_r) : (lw_valid_r && (a_idx_r == lw_idx_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (adv_a) begin
      b_valid_r <= 1'b1;
    end else if (adv_b) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      b_idx_r  <= a_idx_r;
      b_luma_r <= a_luma_r;
      b_init_r <= a_init_r;
      b_oor_r  <= b_oor_nxt;
      b_fwd_r  <= b_fwd_nxt;
      b_p_r    <= b_p_nxt;
    end
  end

  // state RAM
  logic [WORD_W-1:0] ram_rdata;
  bsp_word_t         ram_word;
  bsp_word_t         wr_word;

  assign ram_word = bsp_word_t'(ram_rdata);

  bsp_ram #(
    .WIDTH (WORD_W),
    .DEPTH (PIXEL_COUNT)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr_now),
    .waddr (PIX_AW'(b_idx_r)),
    .wdata (wr_word),
    .re    (adv_a),
    .raddr (PIX_AW'(a_idx_r)),
    .rdata (ram_rdata)
  );

  // stage B update
  logic [PIX_W-1:0]   bkg_old;
  logic [CNT_W-1:0]   cnt_old;
  logic [PIX_W-1:0]   diff;
  logic               is_fg;
  logic [CNT_W-1:0]   cnt_inc;
  logic [ALPHA_W-1:0] alpha_inv;
  logic [16:0]        b_prod;
  logic [16:0]        blend_sum;
  logic [PIX_W-1:0]   blend;
  logic [PIX_W-1:0]   bkg_new;
  logic [CNT_W-1:0]   cnt_new;
  logic               fg_new;

  always_comb begin
    bkg_old   = b_fwd_r ? lw_bkg_r : ram_word.bkg;
    cnt_old   = b_fwd_r ? lw_cnt_r : ram_word.cnt;
    diff      = (b_luma_r > bkg_old) ? (b_luma_r - bkg_old) : (bkg_old - b_luma_r);
    is_fg     = (diff > thr_r);
    cnt_inc   = (cnt_old == CNT_MAX) ? CNT_MAX : (cnt_old + 8'd1);
    alpha_inv = ALPHA_ONE - alpha_r;
    b_prod    = alpha_inv * bkg_old;
    // a*cur + (256-a)*bkg + 128 never exceeds 16 bits
    blend_sum = {1'b0, b_p_r} + b_prod;
    blend     = blend_sum[15:8];

    bkg_new = blend;
    cnt_new = cnt_old;
    fg_new  = is_fg;
    if (b_init_r) begin
      bkg_new = b_luma_r;
      cnt_new = '0;
      fg_new  = 1'b0;
    end else if (sel_r) begin
      if (is_fg) begin
        cnt_new = cnt_inc;
        // ghost removal: long-standing foreground is absorbed
        bkg_new = (cnt_inc > limit_r) ? b_luma_r : bkg_old;
      end else begin
        cnt_new = '0;
      end
    end
  end

  assign wr_word.bkg = bkg_new;
  assign wr_word.cnt = cnt_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_valid_r <= 1'b0;
    end else if (wr_now) begin
      lw_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_now) begin
      lw_idx_r <= b_idx_r;
      lw_bkg_r <= bkg_new;
      lw_cnt_r <= cnt_new;
    end
  end

  // stage C: output register
  logic             c_fg_r;
  logic [PIX_W-1:0] c_bkg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (adv_b) begin
      c_valid_r <= 1'b1;
    end else if (out_xfer) begin
      c_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_b) begin
      c_fg_r  <= b_oor_r ? 1'b0 : fg_new;
      c_bkg_r <= b_oor_r ? '0 : bkg_new;
    end
  end

  assign out_valid            = c_valid_r;
  assign out_foreground       = c_fg_r;
  assign out_background_value = c_bkg_r;

`ifndef NO_ASSERTIONS
  // the input only stalls when stage A holds an item that cannot move
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (a_valid_r && b_valid_r && c_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

  // forwarding always points at the entry of this pixel
  a_fwd_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && b_fwd_r) |-> (lw_valid_r && (lw_idx_r == b_idx_r)))
    else $error("forwarded state belongs to another pixel");

  // a RAM read is only issued when stage B is free to take the data
  a_read_into_free_b: assert property (@(posedge clk) disable iff (!rst_n)
    adv_a |-> (!b_valid_r || adv_b))
    else $error("RAM read would overwrite pending stage B data");

  // every new result comes from stage B
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (c_valid_r && !$past(c_valid_r && out_stall)) |-> $past(b_valid_r))
    else $error("result appeared without a stage B item");
`endif

endmodule

`default_nettype wire

>>> src/bsp_ram.sv
// ----------------------------------------------------------------------------
// bsp_ram
// Generic single-write, single-read RAM with registered read data.
// Read data holds while the read enable is low; a read of the address being
// written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module bsp_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 256,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
